### rtl/waveform_generator_with_noise_defines.svh
// Assertion macros used by the generator's top-level RTL.
`ifndef WAVEFORM_GENERATOR_WITH_NOISE_DEFINES_SVH
`define WAVEFORM_GENERATOR_WITH_NOISE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WGN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WGN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/wgn_pkg.sv
package wgn_pkg;

  localparam int SINE_TABLE_BITS_DEF = 8;
  localparam int PHASE_BITS_DEF      = 16;

  localparam int TIME_W    = 64;
  localparam int VAL_W     = 40;
  localparam int PER_W     = 32;
  localparam int LVL_W     = 39;
  localparam int RNG_W     = 32;
  localparam int SHAPE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 40;
  localparam int WIDE_W    = 48;
  localparam int SHP_VAL_W = 18;
  localparam int NOISE_W   = 24;
  localparam int MUL_A_W   = 41;
  localparam int MUL_B_W   = 25;
  localparam int MUL_P_W   = 66;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 3'd5;

  localparam logic [SHAPE_W-1:0] SHP_SINE     = 3'd0;
  localparam logic [SHAPE_W-1:0] SHP_RAMP     = 3'd1;
  localparam logic [SHAPE_W-1:0] SHP_SQUARE   = 3'd2;
  localparam logic [SHAPE_W-1:0] SHP_TRIANGLE = 3'd3;
  localparam logic [SHAPE_W-1:0] SHP_CONST    = 3'd4;
  localparam logic [SHAPE_W-1:0] SHP_WALK     = 3'd5;

  localparam logic [VAL_W-1:0] AMP_RESET    = 40'd65536;
  localparam logic [PER_W-1:0] PERIOD_RESET = 32'd10000000;
  localparam logic [RNG_W-1:0] SEED_RESET   = 32'd2463534242;

  localparam logic [MUL_B_W-1:0] WALK_GAIN_Q16 = 25'd1311;
  localparam logic [MUL_B_W-1:0] WALK_LEAK_Q20 = 25'd1049;

  // Datapath actions issued by the controller, one per cycle.
  localparam int ACT_W = 5;
  localparam logic [ACT_W-1:0] ACT_NONE    = 5'd0;
  localparam logic [ACT_W-1:0] ACT_START   = 5'd1;
  localparam logic [ACT_W-1:0] ACT_CAPTURE = 5'd2;
  localparam logic [ACT_W-1:0] ACT_DIV_MOD = 5'd3;
  localparam logic [ACT_W-1:0] ACT_DIV_PH  = 5'd4;
  localparam logic [ACT_W-1:0] ACT_PH_LOAD = 5'd5;
  localparam logic [ACT_W-1:0] ACT_ROM     = 5'd6;
  localparam logic [ACT_W-1:0] ACT_SHAPE   = 5'd7;
  localparam logic [ACT_W-1:0] ACT_MUL_AS  = 5'd8;
  localparam logic [ACT_W-1:0] ACT_BASE    = 5'd9;
  localparam logic [ACT_W-1:0] ACT_DRAW    = 5'd10;
  localparam logic [ACT_W-1:0] ACT_MUL_AN  = 5'd11;
  localparam logic [ACT_W-1:0] ACT_STEP    = 5'd12;
  localparam logic [ACT_W-1:0] ACT_MUL_S   = 5'd13;
  localparam logic [ACT_W-1:0] ACT_WALK1   = 5'd14;
  localparam logic [ACT_W-1:0] ACT_MUL_D   = 5'd15;
  localparam logic [ACT_W-1:0] ACT_WALK2   = 5'd16;
  localparam logic [ACT_W-1:0] ACT_MUL_N   = 5'd17;
  localparam logic [ACT_W-1:0] ACT_NTERM   = 5'd18;
  localparam logic [ACT_W-1:0] ACT_SUM     = 5'd19;

  typedef struct packed {
    logic [ACT_W-1:0] act;
  } dp_cmd_t;

  typedef struct packed {
    logic running;
    logic walk_mode;
    logic period_zero;
    logic div_busy;
    logic div_done;
    logic mul_busy;
    logic mul_done;
    logic out_free;
  } dp_status_t;

  // One quarter-wave entry: Q30 Horner series of sin, rounded to Q16.
  function automatic logic [16:0] sine_entry(input int unsigned k, input int unsigned stb);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] one;
    logic [63:0] res;
    one = 64'd1 << 30;
    a   = (64'(k) * 64'd1686629713) >> stb;
    a2  = (a * a) >> 30;
    t   = one - a2 / 72;
    t   = one - ((a2 * t) >> 30) / 42;
    t   = one - ((a2 * t) >> 30) / 20;
    t   = one - ((a2 * t) >> 30) / 6;
    res = (((a * t) >> 30) + 64'd8192) >> 14;
    return res[16:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat40(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 48'sd549755813887;
    lo = -48'sd549755813888;
    if (v > hi) begin
      return hi[VAL_W-1:0];
    end else if (v < lo) begin
      return lo[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

### rtl/wgn_ctrl.sv
module wgn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_start,
  input  wgn_pkg::dp_status_t status,
  output logic                in_ready,
  output wgn_pkg::dp_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MOD  = 5'd1;
  localparam logic [4:0] S_MODW = 5'd2;
  localparam logic [4:0] S_PH   = 5'd3;
  localparam logic [4:0] S_PHW  = 5'd4;
  localparam logic [4:0] S_ROM  = 5'd5;
  localparam logic [4:0] S_SHP  = 5'd6;
  localparam logic [4:0] S_MAS  = 5'd7;
  localparam logic [4:0] S_MASW = 5'd8;
  localparam logic [4:0] S_DRAW = 5'd9;
  localparam logic [4:0] S_MN   = 5'd10;
  localparam logic [4:0] S_MNW  = 5'd11;
  localparam logic [4:0] S_SUM  = 5'd12;
  localparam logic [4:0] S_WD   = 5'd13;
  localparam logic [4:0] S_WM1  = 5'd14;
  localparam logic [4:0] S_WM1W = 5'd15;
  localparam logic [4:0] S_WM2  = 5'd16;
  localparam logic [4:0] S_WM2W = 5'd17;
  localparam logic [4:0] S_WM3  = 5'd18;
  localparam logic [4:0] S_WM3W = 5'd19;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.act   = wgn_pkg::ACT_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_start) begin
            cmd.act = wgn_pkg::ACT_START;
          end else if (status.running) begin
            cmd.act = wgn_pkg::ACT_CAPTURE;
            if (status.walk_mode) begin
              state_nxt = S_WD;
            end else if (status.period_zero) begin
              state_nxt = S_ROM;
            end else begin
              state_nxt = S_MOD;
            end
          end
        end
      end
      S_MOD: begin
        cmd.act   = wgn_pkg::ACT_DIV_MOD;
        state_nxt = S_MODW;
      end
      S_MODW: begin
        if (status.div_done) state_nxt = S_PH;
      end
      S_PH: begin
        cmd.act   = wgn_pkg::ACT_DIV_PH;
        state_nxt = S_PHW;
      end
      S_PHW: begin
        if (status.div_done) begin
          cmd.act   = wgn_pkg::ACT_PH_LOAD;
          state_nxt = S_ROM;
        end
      end
      S_ROM: begin
        cmd.act   = wgn_pkg::ACT_ROM;
        state_nxt = S_SHP;
      end
      S_SHP: begin
        cmd.act   = wgn_pkg::ACT_SHAPE;
        state_nxt = S_MAS;
      end
      S_MAS: begin
        cmd.act   = wgn_pkg::ACT_MUL_AS;
        state_nxt = S_MASW;
      end
      S_MASW: begin
        if (status.mul_done) begin
          cmd.act   = wgn_pkg::ACT_BASE;
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        cmd.act   = wgn_pkg::ACT_DRAW;
        state_nxt = S_MN;
      end
      S_MN: begin
        cmd.act   = wgn_pkg::ACT_MUL_N;
        state_nxt = S_MNW;
      end
      S_MNW: begin
        if (status.mul_done) begin
          cmd.act   = wgn_pkg::ACT_NTERM;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (status.out_free) begin
          cmd.act   = wgn_pkg::ACT_SUM;
          state_nxt = S_IDLE;
        end
      end
      S_WD: begin
        cmd.act   = wgn_pkg::ACT_DRAW;
        state_nxt = S_WM1;
      end
      S_WM1: begin
        cmd.act   = wgn_pkg::ACT_MUL_AN;
        state_nxt = S_WM1W;
      end
      S_WM1W: begin
        if (status.mul_done) begin
          cmd.act   = wgn_pkg::ACT_STEP;
          state_nxt = S_WM2;
        end
      end
      S_WM2: begin
        cmd.act   = wgn_pkg::ACT_MUL_S;
        state_nxt = S_WM2W;
      end
      S_WM2W: begin
        if (status.mul_done) begin
          cmd.act   = wgn_pkg::ACT_WALK1;
          state_nxt = S_WM3;
        end
      end
      S_WM3: begin
        cmd.act   = wgn_pkg::ACT_MUL_D;
        state_nxt = S_WM3W;
      end
      S_WM3W: begin
        if (status.mul_done) begin
          cmd.act   = wgn_pkg::ACT_WALK2;
          state_nxt = S_DRAW;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/wgn_dp.sv
module wgn_dp #(
  parameter int SINE_TABLE_BITS = wgn_pkg::SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = wgn_pkg::PHASE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wgn_pkg::dp_cmd_t                   cmd,
  input  logic [wgn_pkg::TIME_W-1:0]         in_now,
  input  logic                               cfg_wr_en,
  input  logic [wgn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wgn_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [wgn_pkg::VAL_W-1:0]          out_sample,
  output wgn_pkg::dp_status_t                status
);

  localparam int N      = 1 << SINE_TABLE_BITS;
  localparam int IDX_W  = SINE_TABLE_BITS + 1;
  localparam int QB     = PHASE_BITS - 2;
  localparam int DCNT_W = $clog2(wgn_pkg::TIME_W + 1);
  localparam int MCNT_W = $clog2(wgn_pkg::MUL_B_W);
  localparam int PW     = wgn_pkg::MUL_P_W;
  localparam int WW     = wgn_pkg::WIDE_W;

  // Configuration registers.
  logic [wgn_pkg::SHAPE_W-1:0]      shape_sel_r;
  logic signed [wgn_pkg::VAL_W-1:0] amp_r;
  logic signed [wgn_pkg::VAL_W-1:0] off_r;
  logic [wgn_pkg::PER_W-1:0]        period_r;
  logic [wgn_pkg::LVL_W-1:0]        level_r;

  // Generator state.
  logic [wgn_pkg::TIME_W-1:0]       start_r;
  logic [wgn_pkg::RNG_W-1:0]        rng_r;
  logic signed [wgn_pkg::VAL_W-1:0] walk_r;
  logic                             running_r;

  // Working registers.
  logic [wgn_pkg::TIME_W-1:0]           diff_r;
  logic [PHASE_BITS-1:0]                phase_r;
  logic [16:0]                          rom_q_r;
  logic signed [wgn_pkg::SHP_VAL_W-1:0] shape_r;
  logic signed [wgn_pkg::NOISE_W-1:0]   n_r;
  logic signed [wgn_pkg::MUL_A_W-1:0]   step_r;
  logic signed [WW-1:0]                 base_r;
  logic signed [WW-1:0]                 nterm_r;
  logic [wgn_pkg::VAL_W-1:0]            out_r;
  logic                                 out_valid_r;

  // Restoring divider.
  logic [wgn_pkg::PER_W-1:0]  drem_r;
  logic [wgn_pkg::TIME_W-1:0] ddvd_r;
  logic [PHASE_BITS-1:0]      dquo_r;
  logic [DCNT_W-1:0]          dcnt_r;
  logic                       dbusy_r;
  logic                       ddone_r;
  logic [wgn_pkg::PER_W:0]    drem2;
  logic                       dfit;

  // Shift-and-add multiplier, two's complement multiplier operand.
  logic signed [PW-1:0]              mc_r;
  logic [wgn_pkg::MUL_B_W-1:0]       mb_r;
  logic signed [PW-1:0]              acc_r;
  logic [MCNT_W-1:0]                 mcnt_r;
  logic                              mbusy_r;
  logic                              mdone_r;
  logic signed [wgn_pkg::MUL_A_W-1:0] ma;
  logic [wgn_pkg::MUL_B_W-1:0]       mb;
  logic                              mgo;

  logic [16:0] rom [0:N];

  for (genvar g = 0; g <= N; g++) begin : g_rom
    assign rom[g] = wgn_pkg::sine_entry(g, SINE_TABLE_BITS);
  end

  function automatic logic signed [PW-1:0] rnd_shr(input logic signed [PW-1:0] p,
                                                   input int unsigned s);
    logic signed [PW-1:0] one;
    one = PW'(1);
    return (p + (one <<< (s - 1))) >>> s;
  endfunction

  // Phase decoding for the sine table index and the other shapes; xorshift next state and walk sum.
  logic [63:0]           ph64;
  logic [63:0]           ramp_f;
  logic [63:0]           tri_f;
  logic [63:0]           sin_i;
  logic [IDX_W-1:0]      sin_idx;
  logic                  below_half;
  logic signed [19:0]    shape_c;
  logic [wgn_pkg::RNG_W-1:0] rng_a;
  logic [wgn_pkg::RNG_W-1:0] rng_b;
  logic [wgn_pkg::RNG_W-1:0] rng_c;
  logic signed [WW-1:0]  walk_sum;

  always_comb begin
    ph64       = 64'(phase_r);
    ramp_f     = (ph64 << 17) >> PHASE_BITS;
    tri_f      = (ph64 << 18) >> PHASE_BITS;
    sin_i      = (64'(phase_r[QB-1:0]) << SINE_TABLE_BITS) >> QB;
    sin_idx    = phase_r[QB] ? IDX_W'(N) - sin_i[IDX_W-1:0] : sin_i[IDX_W-1:0];
    below_half = !phase_r[PHASE_BITS-1];
    case (shape_sel_r)
      wgn_pkg::SHP_RAMP:     shape_c = signed'({2'b00, ramp_f[17:0]}) - 20'sd65536;
      wgn_pkg::SHP_SQUARE:   shape_c = below_half ? 20'sd65536 : -20'sd65536;
      wgn_pkg::SHP_TRIANGLE: begin
        if (below_half) begin
          shape_c = signed'({1'b0, tri_f[18:0]}) - 20'sd65536;
        end else begin
          shape_c = 20'sd196608 - signed'({1'b0, tri_f[18:0]});
        end
      end
      wgn_pkg::SHP_CONST:    shape_c = '0;
      default: begin
        if (phase_r[PHASE_BITS-1]) begin
          shape_c = -signed'({3'b000, rom_q_r});
        end else begin
          shape_c = signed'({3'b000, rom_q_r});
        end
      end
    endcase
    rng_a = rng_r ^ (rng_r << 13);
    rng_b = rng_a ^ (rng_a >> 17);
    rng_c = rng_b ^ (rng_b << 5);
    walk_sum = '0;
    case (cmd.act)
      wgn_pkg::ACT_WALK1: walk_sum = WW'(walk_r) + WW'(rnd_shr(acc_r, 16));
      wgn_pkg::ACT_WALK2: walk_sum = WW'(walk_r) + WW'(rnd_shr(acc_r, 20));
      default:            walk_sum = WW'(walk_r);
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mgo = 1'b1;
    ma  = '0;
    mb  = '0;
    case (cmd.act)
      wgn_pkg::ACT_MUL_AS: begin
        ma = wgn_pkg::MUL_A_W'(amp_r);
        mb = wgn_pkg::MUL_B_W'(shape_r);
      end
      wgn_pkg::ACT_MUL_AN: begin
        ma = wgn_pkg::MUL_A_W'(amp_r);
        mb = wgn_pkg::MUL_B_W'(n_r);
      end
      wgn_pkg::ACT_MUL_S: begin
        ma = step_r;
        mb = wgn_pkg::WALK_GAIN_Q16;
      end
      wgn_pkg::ACT_MUL_D: begin
        ma = wgn_pkg::MUL_A_W'(off_r) - wgn_pkg::MUL_A_W'(walk_r);
        mb = wgn_pkg::WALK_LEAK_Q20;
      end
      wgn_pkg::ACT_MUL_N: begin
        ma = signed'({2'b00, level_r});
        mb = wgn_pkg::MUL_B_W'(n_r);
      end
      default: mgo = 1'b0;
    endcase
  end

  assign drem2 = {drem_r, ddvd_r[wgn_pkg::TIME_W-1]};
  assign dfit  = (drem2 >= {1'b0, period_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_sel_r <= wgn_pkg::SHP_SINE;
      amp_r       <= wgn_pkg::AMP_RESET;
      off_r       <= '0;
      period_r    <= wgn_pkg::PERIOD_RESET;
      level_r     <= '0;
      rng_r       <= wgn_pkg::SEED_RESET;
      start_r     <= '0;
      walk_r      <= '0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
      dbusy_r     <= 1'b0;
      ddone_r     <= 1'b0;
      mbusy_r     <= 1'b0;
      mdone_r     <= 1'b0;
    end else begin
      ddone_r <= 1'b0;
      mdone_r <= 1'b0;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      if (cfg_wr_en) begin
        case (cfg_index)
          wgn_pkg::REG_WAVE_SHAPE:   shape_sel_r <= cfg_wr_data[wgn_pkg::SHAPE_W-1:0];
          wgn_pkg::REG_AMPLITUDE:    amp_r       <= cfg_wr_data;
          wgn_pkg::REG_OFFSET_LEVEL: off_r       <= cfg_wr_data;
          wgn_pkg::REG_PERIOD_US:    period_r    <= cfg_wr_data[wgn_pkg::PER_W-1:0];
          wgn_pkg::REG_NOISE_LEVEL:  level_r     <= cfg_wr_data[wgn_pkg::LVL_W-1:0];
          wgn_pkg::REG_NOISE_SEED:   rng_r       <= cfg_wr_data[wgn_pkg::RNG_W-1:0];
          default: ;
        endcase
      end

      case (cmd.act)
        wgn_pkg::ACT_START: begin
          start_r   <= in_now;
          walk_r    <= off_r;
          running_r <= 1'b1;
        end
        wgn_pkg::ACT_DRAW:  rng_r <= rng_c;
        wgn_pkg::ACT_WALK1: walk_r <= wgn_pkg::sat40(walk_sum);
        wgn_pkg::ACT_WALK2: walk_r <= wgn_pkg::sat40(walk_sum);
        wgn_pkg::ACT_SUM:   out_valid_r <= 1'b1;
        default: ;
      endcase

      if (cmd.act == wgn_pkg::ACT_DIV_MOD || cmd.act == wgn_pkg::ACT_DIV_PH) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r && dcnt_r == DCNT_W'(1)) begin
        dbusy_r <= 1'b0;
        ddone_r <= 1'b1;
      end

      if (mgo) begin
        mbusy_r <= 1'b1;
      end else if (mbusy_r && mcnt_r == MCNT_W'(wgn_pkg::MUL_B_W - 1)) begin
        mbusy_r <= 1'b0;
        mdone_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.act)
      wgn_pkg::ACT_CAPTURE: begin
        diff_r  <= in_now - start_r;
        phase_r <= '0;
      end
      wgn_pkg::ACT_PH_LOAD: phase_r <= dquo_r;
      wgn_pkg::ACT_ROM:     rom_q_r <= rom[sin_idx];
      wgn_pkg::ACT_SHAPE:   shape_r <= shape_c[wgn_pkg::SHP_VAL_W-1:0];
      wgn_pkg::ACT_BASE:    base_r  <= WW'(off_r) + WW'(rnd_shr(acc_r, 16));
      wgn_pkg::ACT_DRAW:    n_r     <= signed'({~rng_c[23], rng_c[22:0]});
      wgn_pkg::ACT_STEP:    step_r  <= wgn_pkg::MUL_A_W'(rnd_shr(acc_r, 23));
      wgn_pkg::ACT_WALK2:   base_r  <= WW'(wgn_pkg::sat40(walk_sum));
      wgn_pkg::ACT_NTERM:   nterm_r <= WW'(rnd_shr(acc_r, 23));
      wgn_pkg::ACT_SUM:     out_r   <= wgn_pkg::sat40(base_r + nterm_r);
      default: ;
    endcase

    if (cmd.act == wgn_pkg::ACT_DIV_MOD) begin
      drem_r <= '0;
      ddvd_r <= diff_r;
      dcnt_r <= DCNT_W'(wgn_pkg::TIME_W);
    end else if (cmd.act == wgn_pkg::ACT_DIV_PH) begin
      ddvd_r <= '0;
      dquo_r <= '0;
      dcnt_r <= DCNT_W'(PHASE_BITS);
    end else if (dbusy_r) begin
      drem_r <= dfit ? drem2[wgn_pkg::PER_W-1:0] - period_r : drem2[wgn_pkg::PER_W-1:0];
      ddvd_r <= ddvd_r << 1;
      dquo_r <= {dquo_r[PHASE_BITS-2:0], dfit};
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end

    if (mgo) begin
      mc_r   <= PW'(ma);
      mb_r   <= mb;
      acc_r  <= '0;
      mcnt_r <= '0;
    end else if (mbusy_r) begin
      if (mb_r[0]) begin
        if (mcnt_r == MCNT_W'(wgn_pkg::MUL_B_W - 1)) begin
          acc_r <= acc_r - mc_r;
        end else begin
          acc_r <= acc_r + mc_r;
        end
      end
      mc_r   <= mc_r <<< 1;
      mb_r   <= mb_r >> 1;
      mcnt_r <= mcnt_r + MCNT_W'(1);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_r;

  always_comb begin
    status.running     = running_r;
    status.walk_mode   = (shape_sel_r == wgn_pkg::SHP_WALK);
    status.period_zero = (period_r == '0);
    status.div_busy    = dbusy_r;
    status.div_done    = ddone_r;
    status.mul_busy    = mbusy_r;
    status.mul_done    = mdone_r;
    status.out_free    = !out_valid_r || out_ready;
  end

endmodule

### rtl/waveform_generator_with_noise.sv
// Sample request: a valid result follows a 64-step modulo, a PHASE_BITS-step phase division
// and two 25-step multiplies; random walk skips both divisions and runs four multiplies.
// With a zero period the divisions are skipped.
// One request at a time: the next is accepted in the cycle its result turns valid.
// Start request or a request before any start: no result.
// rst_n is synchronous, active low: registers take their reset values, generator disarmed.
`include "waveform_generator_with_noise_defines.svh"

module waveform_generator_with_noise #(
  parameter int SINE_TABLE_BITS = wgn_pkg::SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = wgn_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wgn_pkg::TIME_W-1:0]    in_tdata,    // [63:0] now_us
  input  logic [0:0]                    in_tuser,    // [0] start_req
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wgn_pkg::VAL_W-1:0]     out_tdata,   // [39:0] sample_value
  input  logic                          cfg_wr_en,
  input  logic [wgn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wgn_pkg::CFG_W-1:0]     cfg_wr_data
);

  // The controller steps through the divider and multiplier phases of one
  // request; the datapath holds configuration, generator state, the shared
  // divider and multiplier, and the output register. A result that waits in
  // the output register holds the controller in its final step, so the input
  // stays stalled until the receiver takes the previous result.
  wgn_pkg::dp_cmd_t    cmd;
  wgn_pkg::dp_status_t status;

  wgn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_start (in_tuser[0]),
    .status   (status),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  wgn_dp #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_now      (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_sample  (out_tdata),
    .status      (status)
  );

  // A new request is only taken when neither arithmetic unit is mid-operation.
  `WGN_ASSERT_IMP(a_idle_units, in_tready, !status.div_busy && !status.mul_busy, "unit busy")
  // A result is only loaded into a free output slot.
  `WGN_ASSERT_IMP(a_sum_slot, cmd.act == wgn_pkg::ACT_SUM, !out_tvalid || out_tready, "overrun")
  // An accepted start request arms the generator.
  `WGN_ASSERT_NXT(a_start_arms, in_tvalid && in_tready && in_tuser[0], status.running, "no arm")

endmodule
